// ===== design/cnfp_pkg.sv =====
// Shared types, constants and helper functions for the CNF token parser.
package cnfp_pkg;

	// Width of the number token value (two's complement)
	localparam int VALUE_WIDTH = 32;
	// Width of the literal result field
	localparam int LIT_W = 32;
	// Width of the saturating counts
	localparam int CNT_W = 31;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Magnitude width: holds |most negative value| and compares against CNT_MAX
	localparam int MAG_W = (VALUE_WIDTH + 1 > CNT_W + 1) ? VALUE_WIDTH + 1 : CNT_W + 1;
	// Sign-extension width for the literal
	localparam int SX_W = (VALUE_WIDTH > LIT_W) ? VALUE_WIDTH : LIT_W;

	typedef enum logic [2:0] {
		TK_COMMENT = 3'd0,
		TK_HEADER  = 3'd1,
		TK_NUMBER  = 3'd2,
		TK_ZERO    = 3'd3,
		TK_NEWLINE = 3'd4,
		TK_EOF     = 3'd5,
		TK_SCAN    = 3'd6
	} tok_kind_t;

	typedef enum logic [1:0] {
		RK_LITERAL = 2'd0,
		RK_CLAUSE  = 2'd1,
		RK_OK      = 2'd2,
		RK_FAIL    = 2'd3
	} res_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_SCAN   = 3'd1,
		ERR_DUP    = 3'd2,
		ERR_END    = 3'd3,
		ERR_HEADER = 3'd4,
		ERR_CLAUSE = 3'd5
	} err_code_t;

	// Parse phases: header wait, three header fields, three body phases
	typedef enum logic [2:0] {
		PH_INIT     = 3'd0,
		PH_VARS     = 3'd1,
		PH_CLAUSES  = 3'd2,
		PH_HDR_NL   = 3'd3,
		PH_BETWEEN  = 3'd4,
		PH_IN_CLS   = 3'd5,
		PH_AFTER_Z  = 3'd6
	} phase_t;

	// One result beat
	typedef struct packed {
		res_kind_t                kind;
		logic signed [LIT_W-1:0]  literal;
		err_code_t                err;
		logic [CNT_W-1:0]         declared_vars;
		logic [CNT_W-1:0]         declared_clauses;
		logic [CNT_W-1:0]         largest_var;
		logic [CNT_W-1:0]         clauses_seen;
	} res_t;

	// Absolute value of a token value, saturated to the count width
	function automatic logic [CNT_W-1:0] abs_sat(input logic [VALUE_WIDTH-1:0] v);
		logic [MAG_W-1:0] ext;
		logic [MAG_W-1:0] mag;
		ext = MAG_W'($signed(v));
		mag = v[VALUE_WIDTH-1] ? (~ext + MAG_W'(1)) : ext;
		if (mag > MAG_W'(CNT_MAX))
			return CNT_MAX;
		return mag[CNT_W-1:0];
	endfunction

	// Low literal bits of the sign-extended token value
	function automatic logic [LIT_W-1:0] to_literal(input logic [VALUE_WIDTH-1:0] v);
		logic [SX_W-1:0] sx;
		sx = SX_W'($signed(v));
		return sx[LIT_W-1:0];
	endfunction

endpackage

// ===== design/cnfp_in_stage.sv =====
// Input register stage: holds one token beat until the parser core takes it.
module cnfp_in_stage
	import cnfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2:0]              in_kind,
	input  logic [VALUE_WIDTH-1:0]  in_value,
	input  logic                    advance,
	output logic                    valid_s1,
	output logic [2:0]              kind_s1,
	output logic [VALUE_WIDTH-1:0]  value_s1
);

	// Free when empty or when the held beat moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= in_kind;
			value_s1 <= in_value;
		end
	end

endmodule

// ===== design/cnfp_core.sv =====
// Parser core: phase and count registers plus the per-token transition logic.
module cnfp_core
	import cnfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic [2:0]              kind_s1,
	input  logic [VALUE_WIDTH-1:0]  value_s1,
	output logic                    res_emit,
	output res_t                    res
);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] hvars_q, hvars_d;
	logic [CNT_W-1:0] hcls_q, hcls_d;
	logic [CNT_W-1:0] maxvar_q, maxvar_d;
	logic [CNT_W-1:0] ccount_q, ccount_d;
	logic             halted_q, halted_d;

	logic             neg;
	logic [CNT_W-1:0] mag;
	res_kind_t        rk;
	err_code_t        err;
	logic             take_lit;

	assign neg = value_s1[VALUE_WIDTH-1];
	assign mag = abs_sat(value_s1);

	// State registers, updated when a token is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INIT;
			hvars_q  <= '0;
			hcls_q   <= '0;
			maxvar_q <= '0;
			ccount_q <= '0;
			halted_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			hvars_q  <= hvars_d;
			hcls_q   <= hcls_d;
			maxvar_q <= maxvar_d;
			ccount_q <= ccount_d;
			halted_q <= halted_d;
		end
	end

	// Token transition
	always_comb begin
		phase_d  = phase_q;
		hvars_d  = hvars_q;
		hcls_d   = hcls_q;
		maxvar_d = maxvar_q;
		ccount_d = ccount_q;
		halted_d = halted_q;
		res_emit = 1'b0;
		rk       = RK_LITERAL;
		err      = ERR_NONE;
		take_lit = 1'b0;

		if (halted_q) begin
			// halted: ignore everything
		end else if (kind_s1 >= TK_SCAN) begin
			// scan error, including the unused code
			res_emit = 1'b1;
			rk       = RK_FAIL;
			err      = ERR_SCAN;
		end else if (kind_s1 == TK_COMMENT) begin
			// comments are skipped
		end else begin
			unique case (phase_q)
				PH_INIT: begin
					if (kind_s1 == TK_HEADER) begin
						phase_d = PH_VARS;
					end else if (kind_s1 == TK_EOF) begin
						res_emit = 1'b1;
						rk       = RK_FAIL;
						err      = ERR_END;
					end
				end
				PH_VARS, PH_CLAUSES: begin
					if (kind_s1 != TK_NUMBER || neg) begin
						res_emit = 1'b1;
						rk       = RK_FAIL;
						err      = ERR_HEADER;
					end else if (phase_q == PH_VARS) begin
						hvars_d = mag;
						phase_d = PH_CLAUSES;
					end else begin
						hcls_d  = mag;
						phase_d = PH_HDR_NL;
					end
				end
				PH_HDR_NL: begin
					if (kind_s1 != TK_NEWLINE) begin
						res_emit = 1'b1;
						rk       = RK_FAIL;
						err      = ERR_HEADER;
					end else begin
						phase_d = PH_BETWEEN;
					end
				end
				PH_BETWEEN: begin
					case (kind_s1)
						TK_HEADER: begin
							res_emit = 1'b1;
							rk       = RK_FAIL;
							err      = ERR_DUP;
						end
						TK_EOF: begin
							res_emit = 1'b1;
							if (hvars_q == '0) begin
								rk  = RK_FAIL;
								err = ERR_END;
							end else begin
								rk       = RK_OK;
								halted_d = 1'b1;
							end
						end
						TK_NEWLINE: begin
						end
						TK_NUMBER: begin
							phase_d  = PH_IN_CLS;
							take_lit = 1'b1;
						end
						default: begin
							res_emit = 1'b1;
							rk       = RK_FAIL;
							err      = ERR_CLAUSE;
						end
					endcase
				end
				PH_IN_CLS: begin
					case (kind_s1)
						TK_ZERO:    phase_d = PH_AFTER_Z;
						TK_NEWLINE: begin
						end
						TK_NUMBER:  take_lit = 1'b1;
						default: begin
							res_emit = 1'b1;
							rk       = RK_FAIL;
							err      = ERR_CLAUSE;
						end
					endcase
				end
				PH_AFTER_Z: begin
					if (kind_s1 inside {TK_NEWLINE, TK_EOF}) begin
						if (ccount_q != CNT_MAX)
							ccount_d = ccount_q + CNT_W'(1);
						phase_d  = PH_BETWEEN;
						res_emit = 1'b1;
						rk       = RK_CLAUSE;
					end else begin
						res_emit = 1'b1;
						rk       = RK_FAIL;
						err      = ERR_CLAUSE;
					end
				end
				default: phase_d = PH_INIT;
			endcase
		end

		// Literal pass-through with running maximum
		if (take_lit) begin
			res_emit = 1'b1;
			rk       = RK_LITERAL;
			if (mag > maxvar_q)
				maxvar_d = mag;
		end

		// Any failure halts the parser
		if (rk == RK_FAIL && res_emit)
			halted_d = 1'b1;
	end

	// Result beat built from the post-update state
	always_comb begin
		res.kind             = rk;
		res.literal          = take_lit ? to_literal(value_s1) : '0;
		res.err              = err;
		res.declared_vars    = hvars_d;
		res.declared_clauses = hcls_d;
		res.largest_var      = maxvar_d;
		res.clauses_seen     = ccount_d;
	end

`ifndef SYNTHESIS
	// Once halted, the parser never leaves that state
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");

	// A halted parser produces no results
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_emit)
		else $error("result produced while halted");

	// A consumed failure or success halts the parser
	a_end_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_emit && (rk == RK_FAIL || rk == RK_OK)) |=> halted_q)
		else $error("parser did not halt after final result");

	// The clause count never goes down
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ccount_q >= $past(ccount_q))
		else $error("clause count decreased");
`endif

endmodule

// ===== design/cnfp_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
module cnfp_out_reg
	import cnfp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  res_t  res_in,
	output logic  space,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  res_q
);

	// Room for a new beat when empty or when the held beat is taken now
	assign space = !out_valid || out_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

endmodule

// ===== design/cnf_token_parser_top.sv =====
// Top level of the CNF token parser: input stage, parser core, result register.
//
// Parses a stream of pre-scanned DIMACS CNF tokens, one token per beat on the
// token channel, and sends literal, clause-end, success and failure results on
// the result channel. The block takes one token per clock cycle when the result
// side keeps up. An accepted token is loaded into the input register, then passes
// through the parser core, which loads its result into the result register.
// Tokens that cause no result (comments, header fields, blank newlines) pass
// through the core too and produce nothing. Every token, with or without a
// result, waits in the input register while the result register holds a beat
// that is not taken, and the token channel stalls while both registers are
// full. After a success or failure result the parser stays halted, absorbing
// tokens without results, until the asynchronous reset.
module cnf_token_parser_top
	import cnfp_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           token_valid,
	output logic                           token_ready,
	input  logic [2:0]                     token_kind,
	input  logic signed [VALUE_WIDTH-1:0]  token_value,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [1:0]                     result_kind,
	output logic signed [LIT_W-1:0]        literal,
	output logic [2:0]                     error_code,
	output logic [CNT_W-1:0]               declared_vars,
	output logic [CNT_W-1:0]               declared_clauses,
	output logic [CNT_W-1:0]               largest_var,
	output logic [CNT_W-1:0]               clauses_seen
);

	logic                    valid_s1;
	logic [2:0]              kind_s1;
	logic [VALUE_WIDTH-1:0]  value_s1;
	logic                    advance;
	logic                    space;
	logic                    res_emit;
	res_t                    res_next;
	res_t                    res_q;

	// A held token moves through the core when the result register has room
	assign advance = valid_s1 && space;

	cnfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (token_valid),
		.in_ready (token_ready),
		.in_kind  (token_kind),
		.in_value (token_value),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.kind_s1  (kind_s1),
		.value_s1 (value_s1)
	);

	cnfp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.kind_s1  (kind_s1),
		.value_s1 (value_s1),
		.res_emit (res_emit),
		.res      (res_next)
	);

	cnfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_emit),
		.res_in    (res_next),
		.space     (space),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.res_q     (res_q)
	);

	// Result fields
	assign result_kind      = res_q.kind;
	assign literal          = res_q.literal;
	assign error_code       = res_q.err;
	assign declared_vars    = res_q.declared_vars;
	assign declared_clauses = res_q.declared_clauses;
	assign largest_var      = res_q.largest_var;
	assign clauses_seen     = res_q.clauses_seen;

`ifndef SYNTHESIS
	// Error code is only set on a failure beat
	a_err_only_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && res_q.kind != RK_FAIL) |-> res_q.err == ERR_NONE)
		else $error("error code on a non-failure result");

	// Literal is zero on every non-literal beat
	a_lit_only_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && res_q.kind != RK_LITERAL) |-> res_q.literal == '0)
		else $error("literal set on a non-literal result");
`endif

endmodule

// ===== tb/sv/cnf_token_parser_top_tb.sv =====
// Self-checking testbench for the CNF token parser: directed rows, then a long random CNF body.
`timescale 1ns / 1ps

module cnf_token_parser_top_tb;
	import cnfp_pkg::*;

	localparam int DIRECTED_ROWS    = 25;
	localparam int RANDOM_ITEMS     = 1200;
	localparam int TAIL_ITEMS       = 150;
	localparam int PAUSE_AT         = 700;
	localparam int HALTED_ITEMS     = 8;
	localparam int LONG_HOLD_AT     = 200;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int REPORT_LIMIT     = 10;
	// Kind 7 is outside the scanner's codes and is treated as a scan error
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// One directed row; the typed fields are used only where typed is set
	typedef struct packed {
		tok_kind_t               kind;
		logic [VALUE_WIDTH-1:0]  value;
		bit                      typed;
		res_kind_t               rk;
		logic [LIT_W-1:0]        lit;
		err_code_t               ec;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          token_valid;
	logic                          token_ready;
	logic [2:0]                    token_kind;
	logic signed [VALUE_WIDTH-1:0] token_value;
	logic                          result_valid;
	logic                          result_ready;
	logic [1:0]                    result_kind;
	logic signed [LIT_W-1:0]       literal;
	logic [2:0]                    error_code;
	logic [CNT_W-1:0]              declared_vars;
	logic [CNT_W-1:0]              declared_clauses;
	logic [CNT_W-1:0]              largest_var;
	logic [CNT_W-1:0]              clauses_seen;

	// Parser state mirrored by the predictor
	phase_t           parse_phase  = PH_INIT;
	logic [CNT_W-1:0] hdr_vars     = '0;
	logic [CNT_W-1:0] hdr_clauses  = '0;
	logic [CNT_W-1:0] max_var      = '0;
	logic [CNT_W-1:0] clause_count = '0;
	bit               parse_halted = 1'b0;

	res_t     pending_results [$];
	dir_row_t directed_rows [DIRECTED_ROWS];
	int       items_sent      = 0;
	int       results_checked = 0;
	int       mismatches      = 0;
	int       quiet_cycles    = 0;
	bit       calm            = 1'b0;

	cnf_token_parser_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.token_valid      (token_valid),
		.token_ready      (token_ready),
		.token_kind       (token_kind),
		.token_value      (token_value),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.result_kind      (result_kind),
		.literal          (literal),
		.error_code       (error_code),
		.declared_vars    (declared_vars),
		.declared_clauses (declared_clauses),
		.largest_var      (largest_var),
		.clauses_seen     (clauses_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the parser state by one token and form the result it causes
	task automatic parse_token(input logic [2:0] kind, input logic [VALUE_WIDTH-1:0] value,
		output bit got, output res_t r);
		logic [VALUE_WIDTH:0] wide;
		logic [CNT_W-1:0]     mag;
		logic [LIT_W-1:0]     lit;
		res_kind_t            rk;
		err_code_t            ec;
		bit                   neg;
		got = 1'b0;
		rk  = RK_LITERAL;
		ec  = ERR_NONE;
		lit = '0;
		neg = value[VALUE_WIDTH-1];
		// magnitude saturated to the count width
		wide = neg ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
		mag  = (wide > CNT_MAX) ? CNT_MAX : wide[CNT_W-1:0];
		if (parse_halted || kind == TK_COMMENT) begin
		end else if (kind == TK_SCAN || kind == KIND_UNUSED) begin
			ec = ERR_SCAN;
		end else begin
			case (parse_phase)
			PH_INIT: begin
				if (kind == TK_HEADER)
					parse_phase = PH_VARS;
				else if (kind == TK_EOF)
					ec = ERR_END;
			end
			PH_VARS, PH_CLAUSES: begin
				if (kind != TK_NUMBER || neg)
					ec = ERR_HEADER;
				else if (parse_phase == PH_VARS) begin
					hdr_vars    = mag;
					parse_phase = PH_CLAUSES;
				end else begin
					hdr_clauses = mag;
					parse_phase = PH_HDR_NL;
				end
			end
			PH_HDR_NL: begin
				if (kind != TK_NEWLINE)
					ec = ERR_HEADER;
				else
					parse_phase = PH_BETWEEN;
			end
			PH_BETWEEN: begin
				if (kind == TK_HEADER)
					ec = ERR_DUP;
				else if (kind == TK_EOF) begin
					if (hdr_vars == '0)
						ec = ERR_END;
					else begin
						got          = 1'b1;
						rk           = RK_OK;
						parse_halted = 1'b1;
					end
				end else if (kind == TK_NUMBER) begin
					parse_phase = PH_IN_CLS;
					got = 1'b1;
				end else if (kind != TK_NEWLINE)
					ec = ERR_CLAUSE;
			end
			PH_IN_CLS: begin
				if (kind == TK_ZERO)
					parse_phase = PH_AFTER_Z;
				else if (kind == TK_NUMBER)
					got = 1'b1;
				else if (kind != TK_NEWLINE)
					ec = ERR_CLAUSE;
			end
			PH_AFTER_Z: begin
				if (kind == TK_NEWLINE || kind == TK_EOF) begin
					if (clause_count != CNT_MAX)
						clause_count = clause_count + 1'b1;
					parse_phase = PH_BETWEEN;
					got = 1'b1;
					rk  = RK_CLAUSE;
				end else
					ec = ERR_CLAUSE;
			end
			default: parse_phase = PH_INIT;
			endcase
		end
		// literal beat: track the largest variable
		if (got && rk == RK_LITERAL) begin
			if (mag > max_var)
				max_var = mag;
			lit = LIT_W'($signed(value));
		end
		if (ec != ERR_NONE) begin
			got          = 1'b1;
			rk           = RK_FAIL;
			parse_halted = 1'b1;
		end
		r.kind             = rk;
		r.literal          = lit;
		r.err              = ec;
		r.declared_vars    = hdr_vars;
		r.declared_clauses = hdr_clauses;
		r.largest_var      = max_var;
		r.clauses_seen     = clause_count;
	endtask

	// Random literal: mostly small variables, some full-range and boundary values
	function automatic logic [VALUE_WIDTH-1:0] pick_literal();
		logic [VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
		0: v = VALUE_WIDTH'($urandom);
		1: begin
			case ($urandom_range(0, 4))
			0: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
			1: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			2: v = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
			3: v = '0;
			default: v = '1;
			endcase
		end
		default: begin
			v = VALUE_WIDTH'($urandom_range(1, 50));
			if ($urandom_range(0, 1) == 1)
				v = -v;
		end
		endcase
		return v;
	endfunction

	// Offer one token beat, wait for it to be taken, record what it should produce
	task automatic send_token(input logic [2:0] kind, input logic [VALUE_WIDTH-1:0] value,
		input bit typed = 1'b0, input res_kind_t t_kind = RK_LITERAL,
		input logic [LIT_W-1:0] t_lit = '0, input err_code_t t_err = ERR_NONE);
		bit   got;
		res_t r;
		calm = (items_sent >= RANDOM_ITEMS + DIRECTED_ROWS - TAIL_ITEMS) ||
			((items_sent / 100) % 3 == 2);
		if (!calm && $urandom_range(0, 5) == 0) begin
			token_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		token_valid <= 1'b1;
		token_kind  <= kind;
		token_value <= value;
		@(posedge clk);
		while (!token_ready)
			@(posedge clk);
		parse_token(kind, value, got, r);
		if (typed) begin
			got       = 1'b1;
			r.kind    = t_kind;
			r.literal = t_lit;
			r.err     = t_err;
		end
		if (got)
			pending_results = {pending_results, r};
		items_sent++;
	endtask

	// Compare one result beat with the oldest expectation
	task automatic check_result();
		res_t want;
		results_checked++;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("unexpected result beat: kind %0d literal %0d err %0d",
					result_kind, literal, error_code);
		end else begin
			want = pending_results.pop_front();
			if (result_kind != want.kind || literal != want.literal ||
				error_code != want.err || declared_vars != want.declared_vars ||
				declared_clauses != want.declared_clauses ||
				largest_var != want.largest_var || clauses_seen != want.clauses_seen) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display({"result %0d (exp/act): kind %0d/%0d literal %0d/%0d ",
						"err %0d/%0d vars %0d/%0d clauses %0d/%0d largest %0d/%0d ",
						"seen %0d/%0d"}, results_checked,
						want.kind, result_kind, want.literal, literal,
						want.err, error_code, want.declared_vars, declared_vars,
						want.declared_clauses, declared_clauses,
						want.largest_var, largest_var, want.clauses_seen, clauses_seen);
			end
		end
	endtask

	// Token source: reset, directed rows, random CNF body, terminal tokens, halted tail
	initial begin : token_source
		int clause_len;
		int terminal;
		bit paused_once;
		paused_once = 1'b0;
		arst_n      = 1'b0;
		token_valid = 1'b0;
		token_kind  = TK_COMMENT;
		token_value = '0;
		directed_rows = '{
			'{TK_COMMENT, 32'hFFFF_FFFF, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NUMBER,  32'h8000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_ZERO,    32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NEWLINE, 32'h1234_5678, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_HEADER,  32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NUMBER,  32'h7FFF_FFFF, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NUMBER,  32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NEWLINE, 32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NEWLINE, 32'hDEAD_BEEF, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_COMMENT, 32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NUMBER,  32'h7FFF_FFFF, 1'b1, RK_LITERAL, 32'h7FFF_FFFF, ERR_NONE},
			'{TK_NUMBER,  32'h8000_0000, 1'b1, RK_LITERAL, 32'h8000_0000, ERR_NONE},
			'{TK_NUMBER,  32'hFFFF_FFFF, 1'b1, RK_LITERAL, 32'hFFFF_FFFF, ERR_NONE},
			'{TK_NEWLINE, 32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NUMBER,  32'h0000_0001, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_ZERO,    32'hFFFF_FFFF, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NEWLINE, 32'h0000_0000, 1'b1, RK_CLAUSE,  '0, ERR_NONE},
			'{TK_NUMBER,  32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_COMMENT, 32'h5555_5555, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_ZERO,    32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_EOF,     32'hAAAA_AAAA, 1'b1, RK_CLAUSE,  '0, ERR_NONE},
			'{TK_NUMBER,  32'h5555_5555, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NUMBER,  32'hAAAA_AAAA, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_ZERO,    32'h0000_0000, 1'b0, RK_LITERAL, '0, ERR_NONE},
			'{TK_NEWLINE, 32'h0000_0000, 1'b1, RK_CLAUSE,  '0, ERR_NONE}
		};
		// a zero variable count turns the final end of file into an error
		if ($urandom_range(0, 3) == 0)
			directed_rows[5].value = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_token(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].rk, directed_rows[i].lit, directed_rows[i].ec);

		// well-formed clauses with random literals, comments and blank lines
		while (items_sent < RANDOM_ITEMS + DIRECTED_ROWS) begin
			if (!paused_once && items_sent >= PAUSE_AT) begin
				paused_once = 1'b1;
				token_valid <= 1'b0;
				do
					@(posedge clk);
				while (pending_results.size() != 0);
			end
			if ($urandom_range(0, 9) == 0)
				send_token(($urandom_range(0, 1) == 1) ? TK_COMMENT : TK_NEWLINE, $urandom);
			clause_len = $urandom_range(1, 6);
			for (int i = 0; i < clause_len; i++) begin
				send_token(TK_NUMBER, pick_literal());
				if ($urandom_range(0, 11) == 0)
					send_token(TK_COMMENT, $urandom);
				else if ($urandom_range(0, 14) == 0)
					send_token(TK_NEWLINE, $urandom);
			end
			send_token(TK_ZERO, $urandom);
			send_token(($urandom_range(0, 7) == 0) ? TK_EOF : TK_NEWLINE, $urandom);
		end

		// one ending per run: success or one of the error paths
		terminal = $urandom_range(0, 9);
		case (terminal)
		0, 1, 2, 3: send_token(TK_EOF, $urandom);
		4: send_token(($urandom_range(0, 1) == 1) ? KIND_UNUSED : TK_SCAN, $urandom);
		5: send_token(TK_HEADER, $urandom);
		6: send_token(TK_ZERO, $urandom);
		7, 8: begin
			send_token(TK_NUMBER, pick_literal());
			send_token((terminal == 7) ? TK_HEADER : TK_EOF, $urandom);
		end
		default: begin
			send_token(TK_NUMBER, pick_literal());
			send_token(TK_ZERO, $urandom);
			send_token(TK_NUMBER, pick_literal());
		end
		endcase

		// halted: further tokens are absorbed without results
		repeat (HALTED_ITEMS)
			send_token(3'($urandom_range(0, 6)), $urandom);

		token_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result sink: random stall bursts plus one long hold to back up the pipeline
	initial begin : result_sink
		int stall_left;
		bit held_long;
		stall_left   = 0;
		held_long    = 1'b0;
		result_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				check_result();
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (!held_long && results_checked >= LONG_HOLD_AT) begin
				held_long  = 1'b1;
				stall_left = LONG_HOLD_CYCLES - 1;
				result_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				result_ready <= 1'b0;
			end else
				result_ready <= 1'b1;
		end
	end

	// Watchdog: too long without any beat on either channel
	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((token_valid && token_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/cnfp_pkg.sv
design/cnfp_in_stage.sv
design/cnfp_core.sv
design/cnfp_out_reg.sv
design/cnf_token_parser_top.sv
tb/sv/cnf_token_parser_top_tb.sv
